// ===== rtl/fqd_pkg.sv =====
// Shared types and constants for the FIFO queue with delete by value.
`default_nettype none
package fqd_pkg;

   // Default number of queue entries.
   localparam int DEPTH_DEF = 16;

   // Field widths fixed by the interface.
   localparam int HANDLE_W = 32;
   localparam int MODE_W   = 2;
   localparam int LENGTH_W = 5;

   // Operation codes carried in req_mode.
   localparam logic [MODE_W-1:0] MODE_ENQ = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DEQ = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DEL = 2'd2;
   localparam logic [MODE_W-1:0] MODE_LEN = 2'd3;

   // Status codes.
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // Commands broadcast from the controller to every cell.
   typedef struct packed {
      logic enq;          // write handle into the first empty cell
      logic shift_all;    // every cell takes its right neighbor (dequeue)
      logic shift_front;  // cells at or past the search front take their neighbor
      logic seek_start;   // set the search front at the head
      logic seek_step;    // advance the search front by one cell
   } cell_ctl_type;

endpackage
`default_nettype wire

// ===== rtl/fqd_cell.sv =====
// One queue cell: holds an entry, its valid flag and the search-front flag.
`default_nettype none
module fqd_cell (
   input  wire                                   clock,
   input  wire                                   reset,
   input  fqd_pkg::cell_ctl_type                 ctl,
   input  wire  [fqd_pkg::HANDLE_W-1:0]          enq_handle,
   input  wire  [fqd_pkg::HANDLE_W-1:0]          key,
   input  wire                                   prev_valid,
   input  wire                                   prev_front,
   input  wire  [fqd_pkg::HANDLE_W-1:0]          next_entry,
   input  wire                                   next_valid,
   output logic [fqd_pkg::HANDLE_W-1:0]          entry,
   output logic                                  valid,
   output logic                                  front,
   output logic                                  hit,
   output logic                                  live
);

   logic [fqd_pkg::HANDLE_W-1:0] entry_ff, entry_in;
   logic                         valid_ff, valid_in;
   logic                         front_ff, front_in;
   logic                         tok;

   // Token sits at the first cell of the front.
   assign tok   = front_ff & ~prev_front;
   assign live  = tok & valid_ff;
   assign hit   = live & (entry_ff == key);
   assign entry = entry_ff;
   assign valid = valid_ff;
   assign front = front_ff;

   // Select next entry and valid flag.
   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (ctl.enq) begin
         if (!valid_ff && prev_valid) begin
            entry_in = enq_handle;
            valid_in = 1'b1;
         end
      end else if (ctl.shift_all || (ctl.shift_front && front_ff)) begin
         entry_in = next_entry;
         valid_in = next_valid;
      end
   end

   // Move the search front.
   always_comb begin
      front_in = front_ff;
      if (ctl.seek_start) begin
         front_in = 1'b1;
      end else if (ctl.seek_step) begin
         front_in = prev_front;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         front_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         front_ff <= front_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/fqd_ctrl.sv =====
// Controller: handshakes, entry count, delete search sequencing, result register.
`default_nettype none
module fqd_ctrl #(
   parameter int DEPTH = fqd_pkg::DEPTH_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  [fqd_pkg::MODE_W-1:0]            req_mode,
   input  wire  [fqd_pkg::HANDLE_W-1:0]          req_handle_in,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic                                  rsp_status,
   output logic [fqd_pkg::HANDLE_W-1:0]          rsp_handle_out,
   output logic [fqd_pkg::LENGTH_W-1:0]          rsp_length,
   input  wire  [fqd_pkg::HANDLE_W-1:0]          head_entry,
   input  wire                                   any_hit,
   input  wire                                   any_live,
   output fqd_pkg::cell_ctl_type                 ctl,
   output logic [fqd_pkg::HANDLE_W-1:0]          key
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
   localparam logic [CW-1:0] CNT_ONE  = CW'(1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SEEK = 1'b1;

   logic                         state_ff, state_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [fqd_pkg::HANDLE_W-1:0] key_ff, key_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_status_ff, rsp_status_in;
   logic [fqd_pkg::HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [fqd_pkg::LENGTH_W-1:0] rsp_length_ff, rsp_length_in;
   logic                         accept;
   logic                         load;
   logic                         full;
   logic                         empty;
   logic                         null_h;
   logic [31:0]                  count_wide;

   assign full   = (count_ff == CNT_FULL);
   assign empty  = (count_ff == '0);
   assign null_h = (req_handle_in == '0);

   // Hold requests while searching or while a result waits.
   assign req_stall = (state_ff != ST_IDLE) | (rsp_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;

   assign count_wide = 32'(count_in);

   // Decode the operation and drive the cell commands.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      key_in        = key_ff;
      ctl           = '0;
      load          = 1'b0;
      rsp_status_in = fqd_pkg::STATUS_ERR;
      rsp_handle_in = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  fqd_pkg::MODE_ENQ: begin
                     load = 1'b1;
                     if (!null_h && !full) begin
                        ctl.enq       = 1'b1;
                        count_in      = count_ff + CNT_ONE;
                        rsp_status_in = fqd_pkg::STATUS_OK;
                     end
                  end
                  fqd_pkg::MODE_DEQ: begin
                     load = 1'b1;
                     if (!empty) begin
                        ctl.shift_all = 1'b1;
                        count_in      = count_ff - CNT_ONE;
                        rsp_status_in = fqd_pkg::STATUS_OK;
                        rsp_handle_in = head_entry;
                     end
                  end
                  fqd_pkg::MODE_DEL: begin
                     if (!null_h && !empty) begin
                        ctl.seek_start = 1'b1;
                        key_in         = req_handle_in;
                        state_in       = ST_SEEK;
                     end else begin
                        load = 1'b1;
                     end
                  end
                  default: begin
                     load          = 1'b1;
                     rsp_status_in = fqd_pkg::STATUS_OK;
                  end
               endcase
            end
         end
         ST_SEEK: begin
            // Drop the matching cell, give up past the tail, or advance.
            if (any_hit) begin
               ctl.shift_front = 1'b1;
               count_in        = count_ff - CNT_ONE;
               rsp_status_in   = fqd_pkg::STATUS_OK;
               load            = 1'b1;
               state_in        = ST_IDLE;
            end else if (!any_live) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end else begin
               ctl.seek_step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register: load a beat, clear it once taken.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_length_in = rsp_length_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_length_in = count_wide[fqd_pkg::LENGTH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      rsp_length_ff <= rsp_length_in;
      if (load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_handle_ff <= rsp_handle_in;
      end
   end

   assign key            = key_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_length     = rsp_length_ff;

endmodule
`default_nettype wire

// ===== rtl/fifo_queue_with_delete.sv =====
// Top level: bounded FIFO of non-zero handles with delete by value.
//
// Requests arrive on req_ (valid/stall) with req_mode and req_handle_in:
// enqueue, dequeue, delete the oldest matching handle, or length query.
// Every request returns exactly one beat on rsp_ with status, the handle
// removed by a dequeue (zero otherwise) and the entry count afterward.
// The entries live in a row of cells, head in cell 0; each cell shifts
// toward the head on dequeue and on a delete that compacts past the match.
// For enqueue, dequeue and length the result is registered: it shows on rsp_
// the cycle after the request beat, and such requests can follow every cycle
// while rsp_stall is low. Delete walks a search front one cell per cycle from
// the head until it finds a matching handle or passes the last entry; req_stall
// is high while it walks. Reset empties the queue and clears the result valid
// flag; the result fields and cell contents are not cleared. While rsp_stall
// holds a result, req_stall is raised and no new request is taken until the
// result beat is accepted.
`default_nettype none
module fifo_queue_with_delete #(
   parameter int DEPTH = fqd_pkg::DEPTH_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  [fqd_pkg::MODE_W-1:0]            req_mode,
   input  wire  [fqd_pkg::HANDLE_W-1:0]          req_handle_in,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic                                  rsp_status,
   output logic [fqd_pkg::HANDLE_W-1:0]          rsp_handle_out,
   output logic [fqd_pkg::LENGTH_W-1:0]          rsp_length
);

   fqd_pkg::cell_ctl_type        ctl;
   logic [fqd_pkg::HANDLE_W-1:0] key;
   logic [fqd_pkg::HANDLE_W-1:0] entry [DEPTH];
   logic [DEPTH-1:0]             valid;
   logic [DEPTH-1:0]             front;
   logic [DEPTH-1:0]             hit;
   logic [DEPTH-1:0]             live;
   logic                         any_hit;
   logic                         any_live;

   assign any_hit  = |hit;
   assign any_live = |live;

   fqd_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_handle_in  (req_handle_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_handle_out (rsp_handle_out),
      .rsp_length     (rsp_length),
      .head_entry     (entry[0]),
      .any_hit        (any_hit),
      .any_live       (any_live),
      .ctl            (ctl),
      .key            (key)
   );

   // Build the row of cells; the ends see an always-valid left and empty right.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                         pv;
      logic                         pf;
      logic [fqd_pkg::HANDLE_W-1:0] ne;
      logic                         nv;

      if (i == 0) begin : g_head
         assign pv = 1'b1;
         assign pf = 1'b0;
      end else begin : g_body
         assign pv = valid[i-1];
         assign pf = front[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign ne = '0;
         assign nv = 1'b0;
      end else begin : g_link
         assign ne = entry[i+1];
         assign nv = valid[i+1];
      end

      fqd_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .enq_handle (req_handle_in),
         .key        (key),
         .prev_valid (pv),
         .prev_front (pf),
         .next_entry (ne),
         .next_valid (nv),
         .entry      (entry[i]),
         .valid      (valid[i]),
         .front      (front[i]),
         .hit        (hit[i]),
         .live       (live[i])
      );
   end

endmodule
`default_nettype wire

// ===== rtl/fqd_checker.sv =====
// Port-level checker for the FIFO queue with delete, bound to the top level.
`default_nettype none
module fqd_checker (
   input wire                                   clock,
   input wire                                   reset,
   input wire                                   req_valid,
   input wire                                   req_stall,
   input wire [fqd_pkg::MODE_W-1:0]             req_mode,
   input wire                                   rsp_valid,
   input wire                                   rsp_stall,
   input wire                                   rsp_status,
   input wire [fqd_pkg::HANDLE_W-1:0]           rsp_handle_out,
   input wire [fqd_pkg::LENGTH_W-1:0]           rsp_length
);

   // A held result beat keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_handle_out) && $stable(rsp_length))
      else $error("result beat changed while stalled");

   // No request is taken while a result is held.
   a_req_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request accepted while result held");

   // A failed operation returns no handle.
   a_err_null: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == fqd_pkg::STATUS_ERR |-> rsp_handle_out == '0)
      else $error("error result carries a handle");

   // A length query answers in the next cycle with success.
   a_len_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_mode == fqd_pkg::MODE_LEN
         |=> rsp_valid && rsp_status == fqd_pkg::STATUS_OK
            && rsp_handle_out == '0)
      else $error("length query result missing or wrong");

endmodule

bind fifo_queue_with_delete fqd_checker u_fqd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_mode       (req_mode),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_status     (rsp_status),
   .rsp_handle_out (rsp_handle_out),
   .rsp_length     (rsp_length)
);
`default_nettype wire
